FILE: hw/rtl/rwu_pkg.sv
// rwu_pkg: types, constants and helper functions of the robust weight unit.
// Used by robust_weight_unit; no other dependencies.
package rwu_pkg;

   // Fixed-point formats
   localparam int RES_W    = 17;   // residual, signed Q9.8
   localparam int MAG_W    = 17;   // |residual|, up to 65536
   localparam int SREC_W   = 24;   // 1/sigma, unsigned Q8.16
   localparam int HK_W     = 16;   // Huber k, unsigned Q4.12
   localparam int TREC_W   = 16;   // 1/t, unsigned Q0.16
   localparam int X_W      = 24;   // normalized magnitude, Q8.16
   localparam int K_W      = HK_W + 4;
   localparam int WGT_W    = 17;   // weight, unsigned Q1.16
   localparam int PROD_W   = MAG_W + SREC_W;

   localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(65536);

   // CSR port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // Pipeline: input stage, scale stage, one stage per quotient bit, output stage
   localparam int DIV_STEPS = WGT_W;
   localparam int STAGES    = DIV_STEPS + 3;

   // Reset values of the registers
   localparam logic [1:0]        MODE_RST = 2'd1;
   localparam logic [SREC_W-1:0] SREC_RST = SREC_W'(65536);
   localparam logic [HK_W-1:0]   HK_RST   = HK_W'(5509);
   localparam logic [TREC_W-1:0] TREC_RST = TREC_W'(13988);

   typedef enum logic [1:0] {
      MODE_L2    = 2'd0,
      MODE_HUBER = 2'd1,
      MODE_TUKEY = 2'd2
   } loss_mode_type;

   typedef enum logic [1:0] {
      REG_LOSS_MODE = 2'd0,
      REG_SCALE_REC = 2'd1,
      REG_HUBER_K   = 2'd2,
      REG_TUKEY_REC = 2'd3
   } reg_index_type;

   // One item inside the divider section
   typedef struct packed {
      logic             vreq;     // request valid flag from the input
      logic [X_W-1:0]   x;        // normalized magnitude (divisor)
      logic [X_W-1:0]   rem;      // partial remainder, below x whenever x >= K
      logic [WGT_W-1:0] quo;      // quotient bits so far
      logic [WGT_W-1:0] tk;       // Tukey path: u, then d, then weight
      logic             tk_zero;  // u reached 1.0
      logic             hub_one;  // x below k
   } div_stage_type;

   // Absolute value of a Q9.8 residual; -256.0 gives 65536
   function automatic logic [MAG_W-1:0] abs_residual(input logic signed [RES_W-1:0] r);
      logic [MAG_W-1:0] v;
      v = MAG_W'(r);
      if (r[RES_W-1]) begin
         return MAG_W'(0) - v;
      end
      return v;
   endfunction

   // One restoring division step: shift in the next numerator bit, subtract if it fits
   function automatic div_stage_type div_step(input div_stage_type s, input logic nbit);
      div_stage_type o;
      logic [X_W:0]  t;
      o = s;
      t = {s.rem, nbit};
      if (t >= {1'b0, s.x}) begin
         t     = t - {1'b0, s.x};
         o.quo = {s.quo[WGT_W-2:0], 1'b1};
      end else begin
         o.quo = {s.quo[WGT_W-2:0], 1'b0};
      end
      o.rem = t[X_W-1:0];
      return o;
   endfunction

endpackage

FILE: hw/rtl/robust_weight_unit.sv
// robust_weight_unit: robust M-estimator weights (L2, Huber, Tukey biweight).
// Depends on rwu_pkg for formats, register codes, the stage struct and the divide step.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | req_residual (s17 Q9.8), req_valid_req
//  rsp     | out       | rsp_valid, rsp_stall | rsp_weight (u17 Q1.16)
//  csr     | in/out    | psel/penable/pready  | csr_paddr, csr_pwdata, csr_prdata
//
// One request per cycle sustained while the response is not stalled; stages: input
// register, scale multiply, 17 restoring-divide stages (one Huber quotient bit each,
// Tukey math rides in the first three) and the output register.
// Stages hold their item under stall and fill bubbles; a request is taken whenever any
// stage down to the output is free or the output is being taken.
// Synchronous active-high reset empties the pipeline and loads register defaults.
module robust_weight_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [rwu_pkg::RES_W-1:0]    req_residual,
   input  logic                                req_valid_req,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rwu_pkg::WGT_W-1:0]           rsp_weight,
   // CSR port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rwu_pkg::CSR_AW-1:0]          csr_paddr,
   input  logic [rwu_pkg::CSR_DW-1:0]          csr_pwdata,
   output logic [rwu_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                csr_pready
);
   import rwu_pkg::*;

   localparam int LAST = STAGES - 1;

   // Configuration registers
   loss_mode_type     mode_ff;
   logic [SREC_W-1:0] srec_ff;
   logic [HK_W-1:0]   hk_ff;
   logic [TREC_W-1:0] trec_ff;
   reg_index_type     csr_idx;
   logic              csr_wr;

   // Pipeline registers
   logic [STAGES-1:0] vld_ff, vld_in, rdy;
   logic [MAG_W-1:0]  mag_ff;
   logic              vreq0_ff;
   logic [X_W-1:0]    x1_ff, x1_in;
   logic              vreq1_ff;
   div_stage_type     div_ff [DIV_STEPS];
   div_stage_type     div_in [DIV_STEPS];
   div_stage_type     div_src [DIV_STEPS];
   logic [WGT_W-1:0]  weight_ff, weight_in;

   logic [PROD_W-1:0] scale_prod;
   logic [K_W-1:0]    k_q16;

   assign k_q16 = {hk_ff, 4'b0000};

   // CSR write decode
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= loss_mode_type'(MODE_RST);
         srec_ff <= SREC_RST;
         hk_ff   <= HK_RST;
         trec_ff <= TREC_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_LOSS_MODE: mode_ff <= loss_mode_type'(csr_pwdata[1:0]);
            REG_SCALE_REC: srec_ff <= csr_pwdata[SREC_W-1:0];
            REG_HUBER_K:   hk_ff   <= csr_pwdata[HK_W-1:0];
            REG_TUKEY_REC: trec_ff <= csr_pwdata[TREC_W-1:0];
         endcase
      end
   end

   // CSR read mux
   always_comb begin
      unique case (csr_idx)
         REG_LOSS_MODE: csr_prdata = CSR_DW'(mode_ff);
         REG_SCALE_REC: csr_prdata = CSR_DW'(srec_ff);
         REG_HUBER_K:   csr_prdata = CSR_DW'(hk_ff);
         REG_TUKEY_REC: csr_prdata = CSR_DW'(trec_ff);
      endcase
   end

   // Per-stage flow control: a stage loads when it is empty or its item moves on
   always_comb begin
      rdy[LAST] = !vld_ff[LAST] || !rsp_stall;
      for (int p = LAST - 1; p >= 0; p--) begin
         rdy[p] = !vld_ff[p] || rdy[p+1];
      end
      for (int p = 0; p < STAGES; p++) begin
         if (!rdy[p]) begin
            vld_in[p] = vld_ff[p];
         end else if (p == 0) begin
            vld_in[p] = req_valid;
         end else begin
            vld_in[p] = vld_ff[p-1];
         end
      end
   end

   assign req_stall = !rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Stage 0: magnitude of the residual
   always_ff @(posedge clock) begin
      if (rdy[0] && req_valid) begin
         mag_ff   <= abs_residual(req_residual);
         vreq0_ff <= req_valid_req;
      end
   end

   // Stage 1: x = |r| * (1/sigma) >> 8, saturated to 24 bits
   always_comb begin
      scale_prod = PROD_W'(mag_ff) * PROD_W'(srec_ff);
      if (scale_prod[PROD_W-1:X_W+8] != '0) begin
         x1_in = '1;
      end else begin
         x1_in = scale_prod[X_W+7:8];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1] && vld_ff[0]) begin
         x1_ff    <= x1_in;
         vreq1_ff <= vreq0_ff;
      end
   end

   // Divider section: quotient (K << 16) / x, one bit per stage; Tukey in the first three
   always_comb begin
      logic [X_W+TREC_W-1:0]   u_prod;
      logic [2*TREC_W-1:0]     s_prod;
      logic [2*WGT_W-1:0]      w_prod;
      logic [WGT_W-1:0]        d_val;
      u_prod = '0;
      s_prod = '0;
      w_prod = '0;
      d_val  = '0;

      // seed: remainder starts at K >> 1, which stays below x whenever x >= K
      div_src[0].vreq    = vreq1_ff;
      div_src[0].x       = x1_ff;
      div_src[0].rem     = X_W'(k_q16[K_W-1:1]);
      div_src[0].quo     = '0;
      div_src[0].tk      = '0;
      div_src[0].tk_zero = 1'b0;
      div_src[0].hub_one = X_W'(k_q16) > x1_ff;
      for (int j = 1; j < DIV_STEPS; j++) begin
         div_src[j] = div_ff[j-1];
      end

      for (int j = 0; j < DIV_STEPS; j++) begin
         // numerator bit: only bit 16 of K << 16 can be set below the seed
         div_in[j] = div_step(div_src[j], (j == 0) ? k_q16[0] : 1'b0);
         if (j == 0) begin
            // u = x * (1/t) >> 16
            u_prod            = (X_W+TREC_W)'(div_src[j].x) * (X_W+TREC_W)'(trec_ff);
            div_in[j].tk      = {1'b0, u_prod[TREC_W+15:16]};
            div_in[j].tk_zero = u_prod[X_W+TREC_W-1:TREC_W+16] != '0;
         end else if (j == 1) begin
            // d = 1 - u^2
            s_prod       = (2*TREC_W)'(div_src[j].tk[TREC_W-1:0])
                           * (2*TREC_W)'(div_src[j].tk[TREC_W-1:0]);
            d_val        = ONE_Q16 - WGT_W'(s_prod[2*TREC_W-1:16]);
            div_in[j].tk = d_val;
         end else if (j == 2) begin
            // weight = d^2
            w_prod       = (2*WGT_W)'(div_src[j].tk) * (2*WGT_W)'(div_src[j].tk);
            div_in[j].tk = w_prod[WGT_W+15:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
         if (rdy[j+2] && vld_ff[j+1]) begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   // Output stage: pick the weight for the active loss
   always_comb begin
      div_stage_type f;
      f = div_ff[DIV_STEPS-1];
      case (mode_ff)
         MODE_L2: begin
            weight_in = ONE_Q16;
         end
         MODE_HUBER: begin
            if (!f.vreq || hk_ff == '0) begin
               weight_in = '0;
            end else if (f.hub_one) begin
               weight_in = ONE_Q16;
            end else begin
               weight_in = f.quo;
            end
         end
         MODE_TUKEY: begin
            weight_in = (!f.vreq || f.tk_zero) ? '0 : f.tk;
         end
         default: begin
            weight_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy[LAST] && vld_ff[LAST-1]) begin
         weight_ff <= weight_in;
      end
   end

   assign rsp_valid  = vld_ff[LAST];
   assign rsp_weight = weight_ff;

`ifndef SYNTH
   // Weights never leave [0, 1.0]
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weight <= ONE_Q16))
      else $error("weight above 1.0");

   // Input only stalls when the whole pipeline is full and the output is blocked
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff && rsp_stall))
      else $error("request stalled with a free stage");

   // Huber quotient stays within 1.0 whenever it is used
   a_huber_quo: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[LAST-1] && div_ff[DIV_STEPS-1].vreq && !div_ff[DIV_STEPS-1].hub_one
       && hk_ff != '0) |-> (div_ff[DIV_STEPS-1].quo <= ONE_Q16))
      else $error("Huber quotient out of range");

   // A held response keeps its weight until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_weight)))
      else $error("stalled response changed");
`endif

endmodule

FILE: tb/tb_robust_weight_unit.sv
// Self-checking testbench for robust_weight_unit: predicts each L2/Huber/Tukey weight
// from shadow copies of the CSRs and compares every response in order.
// Depends on rwu_pkg and robust_weight_unit only.
module tb_robust_weight_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import rwu_pkg::*;

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 7;
   localparam int PIPE_LATENCY = STAGES;
   localparam int HOLD_CYCLES  = 120;
   localparam int RANDOM_SEGS  = 9;
   localparam int SEG_ITEMS    = 88;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam longint unsigned X_SAT = (64'd1 << X_W) - 1;
   localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(-65536);
   // register defaults as full-width write data
   localparam logic [CSR_DW-1:0] SREC_DEF = CSR_DW'(SREC_RST);
   localparam logic [CSR_DW-1:0] HK_DEF   = CSR_DW'(HK_RST);
   localparam logic [CSR_DW-1:0] TREC_DEF = CSR_DW'(TREC_RST);

   typedef struct {
      logic signed [RES_W-1:0] residual;
      logic                    valid_flag;
      logic [WGT_W-1:0]        weight;
   } weight_expectation_type;

   // DUT stimulus, known from time zero
   logic                     clock         = 1'b0;
   logic                     reset         = 1'b1;
   logic                     req_valid     = 1'b0;
   logic signed [RES_W-1:0]  req_residual  = '0;
   logic                     req_valid_req = 1'b0;
   logic                     rsp_stall     = 1'b0;
   logic                     csr_psel      = 1'b0;
   logic                     csr_penable   = 1'b0;
   logic                     csr_pwrite    = 1'b0;
   logic [CSR_AW-1:0]        csr_paddr     = '0;
   logic [CSR_DW-1:0]        csr_pwdata    = '0;
   logic                     req_stall;
   logic                     rsp_valid;
   logic [WGT_W-1:0]         rsp_weight;
   logic [CSR_DW-1:0]        csr_prdata;
   logic                     csr_pready;

   // shadow copies of the CSRs
   logic [1:0]               mode_shadow  = MODE_RST;
   logic [SREC_W-1:0]        scale_shadow = SREC_RST;
   logic [HK_W-1:0]          k_shadow     = HK_RST;
   logic [TREC_W-1:0]        trec_shadow  = TREC_RST;

   weight_expectation_type   pending_weights[$];
   int                       send_idle_pct    = 0;
   int                       rsp_idle_pct     = 0;
   bit                       hold_req         = 1'b0;
   int                       fail_count       = 0;
   int                       items_sent       = 0;
   int                       weights_checked  = 0;
   int                       settings_applied = 0;

   robust_weight_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_residual  (req_residual),
      .req_valid_req (req_valid_req),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_weight    (rsp_weight),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // Expected weight for one request under the current shadow settings
   function automatic logic [WGT_W-1:0] predict_weight(input logic signed [RES_W-1:0] r,
                                                       input logic valid_flag);
      longint          sr;
      longint unsigned mag, x, kq, u, s, d;
      sr  = r;
      mag = (sr < 0) ? -sr : sr;
      x   = (mag * scale_shadow) >> 8;
      if (x > X_SAT) x = X_SAT;
      if (mode_shadow == MODE_L2) return ONE_Q16;
      if (!valid_flag) return '0;
      case (mode_shadow)
         MODE_HUBER: begin
            kq = longint'(k_shadow) << 4;
            if (kq == 0) return '0;
            if (x < kq) return ONE_Q16;
            return WGT_W'((kq << 16) / x);
         end
         MODE_TUKEY: begin
            u = (x * trec_shadow) >> 16;
            if (u >= 65536) return '0;
            s = (u * u) >> 16;
            d = 65536 - s;
            return WGT_W'((d * d) >> 16);
         end
         default: return '0;
      endcase
   endfunction

   // Response stall: optional long hold-off, otherwise random at rsp_idle_pct
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= (rsp_idle_pct > 0) && ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Response checker: in-order compare against the oldest expectation
   always @(posedge clock) begin
      weight_expectation_type head;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_weights.size() == 0) begin
            $error("weight %0d arrived with no request outstanding", rsp_weight);
            fail_count++;
         end else begin
            head = pending_weights.pop_front();
            if (rsp_weight !== head.weight) begin
               $error("weight mismatch (residual %0d, valid_req %0b): expected %0d, actual %0d",
                      head.residual, head.valid_flag, head.weight, rsp_weight);
               fail_count++;
            end
            weights_checked++;
         end
      end
   end

   // One request; the sender idles cycle by cycle at send_idle_pct before offering it
   task automatic send_residual(input logic signed [RES_W-1:0] r, input logic valid_flag);
      weight_expectation_type expected;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_residual  <= r;
      req_valid_req <= valid_flag;
      do @(posedge clock); while (req_stall);
      expected = '{r, valid_flag, predict_weight(r, valid_flag)};
      pending_weights.insert(pending_weights.size(), expected);
      items_sent++;
   endtask

   task automatic read_register(input reg_index_type idx, output logic [CSR_DW-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Read back one CSR and compare with its shadow
   task automatic check_register(input reg_index_type idx);
      logic [CSR_DW-1:0] data, wanted;
      read_register(idx, data);
      case (idx)
         REG_LOSS_MODE: wanted = CSR_DW'(mode_shadow);
         REG_SCALE_REC: wanted = CSR_DW'(scale_shadow);
         REG_HUBER_K:   wanted = CSR_DW'(k_shadow);
         default:       wanted = CSR_DW'(trec_shadow);
      endcase
      if (data !== wanted) begin
         $error("register %s readback: expected %0d, actual %0d", idx.name(), wanted, data);
         fail_count++;
      end
   endtask

   task automatic write_register(input reg_index_type idx, input logic [CSR_DW-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // registers keep only their own width
      case (idx)
         REG_LOSS_MODE: mode_shadow  = value[1:0];
         REG_SCALE_REC: scale_shadow = value[SREC_W-1:0];
         REG_HUBER_K:   k_shadow     = value[HK_W-1:0];
         default:       trec_shadow  = value[TREC_W-1:0];
      endcase
      check_register(idx);
   endtask

   // Stop offering requests, let all weights come back and the pipe empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_weights.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [CSR_DW-1:0] mode, input logic [CSR_DW-1:0] srec,
                                input logic [CSR_DW-1:0] k, input logic [CSR_DW-1:0] trec);
      wait_idle();
      write_register(REG_LOSS_MODE, mode);
      write_register(REG_SCALE_REC, srec);
      write_register(REG_HUBER_K, k);
      write_register(REG_TUKEY_REC, trec);
      settings_applied++;
   endtask

   task automatic test_register_reset();
      check_register(REG_LOSS_MODE);
      check_register(REG_SCALE_REC);
      check_register(REG_HUBER_K);
      check_register(REG_TUKEY_REC);
   endtask

   // Field extremes, every mode and the corner cases
   task automatic test_directed_cases();
      // defaults: Huber, k = 1.345, sigma = 1; threshold sits between 344 and 345
      send_residual(17'sd0, 1'b1);
      send_residual(17'sd344, 1'b1);
      send_residual(17'sd345, 1'b1);
      send_residual(RES_MIN, 1'b1);
      send_residual(17'sd65535, 1'b1);
      send_residual(17'sd100, 1'b0);
      // Tukey defaults: u crosses 1.0 between 1199 and 1200
      apply_setting(32'(MODE_TUKEY), SREC_DEF, HK_DEF, TREC_DEF);
      send_residual(17'sd0, 1'b1);
      send_residual(17'sd1199, 1'b1);
      send_residual(-17'sd1200, 1'b1);
      send_residual(17'sd5, 1'b0);
      // L2 ignores the valid flag
      apply_setting(32'(MODE_L2), SREC_DEF, HK_DEF, TREC_DEF);
      send_residual(RES_MIN, 1'b1);
      send_residual(17'sd65535, 1'b0);
      // unused mode always gives zero
      apply_setting(32'(MODE_UNUSED), SREC_DEF, HK_DEF, TREC_DEF);
      send_residual(17'sd100, 1'b1);
      send_residual(17'sd0, 1'b0);
      // Huber with zero k gives zero even at x = 0
      apply_setting(32'(MODE_HUBER), SREC_DEF, 32'd0, TREC_DEF);
      send_residual(17'sd0, 1'b1);
      // Tukey with zero reciprocal gives 1.0
      apply_setting(32'(MODE_TUKEY), SREC_DEF, HK_DEF, 32'd0);
      send_residual(RES_MIN, 1'b1);
      // zero scale: x = 0
      apply_setting(32'(MODE_HUBER), 32'd0, HK_DEF, TREC_DEF);
      send_residual(17'sd65535, 1'b1);
      apply_setting(32'(MODE_TUKEY), 32'd0, HK_DEF, TREC_DEF);
      send_residual(RES_MIN, 1'b1);
      // saturated x, Huber divides by the clamp
      apply_setting(32'(MODE_HUBER), 32'hFF_FFFF, 32'hFFFF, TREC_DEF);
      send_residual(RES_MIN, 1'b1);
      send_residual(17'sd1, 1'b1);
      // all-ones writes are masked per register
      apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_residual(17'sd65535, 1'b1);
   endtask

   // Random settings and residuals under three idling profiles
   task automatic test_random_traffic();
      int                      seg, n;
      logic [CSR_DW-1:0]       m, s, k, t;
      logic signed [RES_W-1:0] r;
      for (seg = 0; seg < RANDOM_SEGS; seg++) begin
         case (seg / 3)
            0: begin
               send_idle_pct = 33;
               rsp_idle_pct  = 76;
            end
            1: begin
               send_idle_pct = 76;
               rsp_idle_pct  = 33;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         n = $urandom_range(0, 9);
         if (n == 0) m = 32'(MODE_L2);
         else if (n == 1) m = 32'(MODE_UNUSED);
         else if (n < 6) m = 32'(MODE_HUBER);
         else m = 32'(MODE_TUKEY);
         case ($urandom_range(0, 5))
            0: s = 32'd0;
            1: s = 32'hFF_FFFF;
            2: s = SREC_DEF;
            3: s = $urandom;
            default: s = $urandom_range(1, 1 << 18);
         endcase
         case ($urandom_range(0, 4))
            0: k = 32'd0;
            1: k = 32'hFFFF;
            2: k = HK_DEF;
            default: k = $urandom;
         endcase
         case ($urandom_range(0, 4))
            0: t = 32'd0;
            1: t = 32'hFFFF;
            2: t = TREC_DEF;
            default: t = $urandom;
         endcase
         apply_setting(m, s, k, t);
         // log-spread magnitudes so both sides of each threshold get hit
         for (n = 0; n < SEG_ITEMS; n++) begin
            r = RES_W'($urandom);
            r = r >>> $urandom_range(0, 16);
            send_residual(r, $urandom_range(99) < 85);
         end
      end
   endtask

   // Long response hold-off while requests keep coming: the pipe must fill and stall
   task automatic test_backpressure();
      int                      n;
      logic signed [RES_W-1:0] r;
      apply_setting(32'(MODE_TUKEY), SREC_DEF, HK_DEF, TREC_DEF);
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_req      = 1'b1;
      for (n = 0; n < 80; n++) begin
         r = RES_W'($urandom);
         r = r >>> $urandom_range(4, 16);
         send_residual(r, $urandom_range(99) < 90);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_register_reset();
      test_directed_cases();
      test_random_traffic();
      test_backpressure();
      wait_idle();
      $display("Sent %0d requests, checked %0d weights over %0d CSR settings,",
               items_sent, weights_checked, settings_applied);
      $display("covering L2, Huber, Tukey, unused mode, masking, idling and a long hold-off.");
      if (fail_count == 0) begin
         $display("robust_weight_unit verification clean");
      end else begin
         $display("robust_weight_unit verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("robust_weight_unit verification failed");
      $finish;
   end

endmodule
